FILE: design/ttc_pkg.sv
// Package for the triggered trace capture block: opcodes, register map,
// reset values and the structs passed between its modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

  // Default sizing of the trace store
  localparam int DEF_DEPTH        = 256;
  localparam int DEF_SAMPLE_WIDTH = 32;

  // Fixed field widths
  localparam int OPCODE_W    = 3;
  localparam int STATE_W     = 8;
  localparam int OFFSET_W    = 8;
  localparam int DIVIDER_W   = 16;
  localparam int THRESHOLD_W = 8;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_DIVIDER   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_THRESHOLD = 1'd1;

  localparam logic [DIVIDER_W-1:0]   DIVIDER_RESET   = 16'd10;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd128;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 3'd0,
    OP_ARM       = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_READ_IDX  = 3'd4,
    OP_READ_LAST = 3'd5,
    OP_POLL      = 3'd6
  } ttc_op_t;

  typedef struct packed {
    logic [DIVIDER_W-1:0]   sample_divider;
    logic [THRESHOLD_W-1:0] safety_threshold;
  } ttc_cfg_t;

  // Per-transaction status carried alongside the read data
  typedef struct packed {
    logic is_read;
    logic seen;
    logic capturing;
  } ttc_flags_t;

endpackage

`default_nettype wire

FILE: design/triggered_trace_capture.sv
// Triggered trace capture, top level. A result passes the holding stage, then the
// output register, where out_valid rises; out_stall can hold it in between.
// Throughput: one transaction per cycle while in_stall is low; the control state
// updates in one pass and the trace store takes one write or one registered read per
// transaction. Reset: synchronous, active low; afterwards a zeroing sweep clears the
// trace store, with in_stall high. Config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module triggered_trace_capture
  import ttc_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int PW          = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [OPCODE_W-1:0]     in_opcode,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic [STATE_W-1:0]      in_task_state,
  input  wire logic [STATE_W-1:0]      in_arm_event,
  input  wire logic [OFFSET_W-1:0]     in_read_offset,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [SAMPLE_WIDTH-1:0] out_read_data,
  output logic                         out_event_seen,
  output logic                         out_capturing,
  output logic      [PW-1:0]           out_write_index,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [PADDR_W-1:0]      paddr,
  input  wire logic [PDATA_W-1:0]      pwdata,
  output logic      [PDATA_W-1:0]      prdata,
  output logic                         pready
);

  ttc_cfg_t                cfg;
  ttc_flags_t              flags;
  logic [PW-1:0]           widx;
  logic                    accept;
  logic                    can_accept;
  logic                    mem_busy;
  logic                    mem_wr_en;
  logic [PW-1:0]           mem_wr_addr;
  logic [SAMPLE_WIDTH-1:0] mem_wr_data;
  logic [PW-1:0]           mem_rd_addr;
  logic [SAMPLE_WIDTH-1:0] mem_rd_data;

  // A transaction is taken when the store is not busy and the holding stage
  // is free or drains into the output register this cycle, so a result
  // stalled in the output register does not block the next input.
  assign in_stall = mem_busy || !can_accept;
  assign accept   = in_valid && !in_stall;

  ttc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pointer, divider, trigger and post-trigger count; all updated at the
  // acceptance edge, together with the store write of a tick.
  ttc_ctrl #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opcode      (in_opcode),
    .sample      (in_sample),
    .task_state  (in_task_state),
    .arm_event   (in_arm_event),
    .read_offset (in_read_offset),
    .cfg         (cfg),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .flags       (flags),
    .write_index (widx)
  );

  // Read data is registered at the acceptance edge. A write and a read
  // never come from the same transaction, so no bypass is needed.
  ttc_trace_mem #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  ttc_out_queue #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .flags_in        (flags),
    .widx_in         (widx),
    .rd_data         (mem_rd_data),
    .can_accept      (can_accept),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_event_seen  (out_event_seen),
    .out_capturing   (out_capturing),
    .out_write_index (out_write_index)
  );

endmodule

`default_nettype wire

FILE: design/ttc_cfg_regs.sv
// APB-style configuration registers: sample divider and safety threshold.
// Depends on ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttc_cfg_regs
  import ttc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output ttc_cfg_t                cfg
);

  ttc_cfg_t              cfg_r;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_divider   <= DIVIDER_RESET;
      cfg_r.safety_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_DIVIDER:   cfg_r.sample_divider   <= pwdata[DIVIDER_W-1:0];
        REG_SAFETY_THRESHOLD: cfg_r.safety_threshold <= pwdata[THRESHOLD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_DIVIDER:   prdata = PDATA_W'(cfg_r.sample_divider);
      REG_SAFETY_THRESHOLD: prdata = PDATA_W'(cfg_r.safety_threshold);
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ttc_trace_mem.sv
// Trace store: one write and one registered read per cycle while not busy,
// plus the zeroing sweep that runs after reset. Depends on ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttc_trace_mem
  import ttc_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int PW          = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [PW-1:0]           wr_addr,
  input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [PW-1:0]           rd_addr,
  output logic      [SAMPLE_WIDTH-1:0] rd_data,
  output logic                         busy
);

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic [PW-1:0]           clr_addr_r;
  logic                    busy_r;
  logic                    mem_we;
  logic [PW-1:0]           mem_addr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;

  assign busy      = busy_r;
  assign rd_data   = rd_data_r;
  assign mem_we    = busy_r || wr_en;
  assign mem_addr  = busy_r ? clr_addr_r : wr_addr;
  assign mem_wdata = busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      if (clr_addr_r == PW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/ttc_ctrl.sv
// Control state of the trace capture: pointer, tick divider, trigger and
// post-trigger count, done flag; forms the memory access. Depends on ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttc_ctrl
  import ttc_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int PW          = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire logic [OPCODE_W-1:0]     opcode,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic [STATE_W-1:0]      task_state,
  input  wire logic [STATE_W-1:0]      arm_event,
  input  wire logic [OFFSET_W-1:0]     read_offset,
  input  wire ttc_cfg_t                cfg,
  output logic                         mem_wr_en,
  output logic      [PW-1:0]           mem_wr_addr,
  output logic      [SAMPLE_WIDTH-1:0] mem_wr_data,
  output logic      [PW-1:0]           mem_rd_addr,
  output ttc_flags_t                   flags,
  output logic      [PW-1:0]           write_index
);

  localparam int RW        = $clog2(DEPTH / 2 + 1);
  localparam int OFF_RANGE = 2 ** OFFSET_W;

  typedef logic [PW-1:0] off_tab_t [OFF_RANGE];

  function automatic off_tab_t build_off_tab();
    off_tab_t t;
    for (int i = 0; i < OFF_RANGE; i++) begin
      t[i] = PW'(i % DEPTH);
    end
    return t;
  endfunction

  // read_offset reduced modulo the store depth
  localparam off_tab_t OFF_TAB = build_off_tab();

  logic [PW-1:0]        wp_r,   wp_nxt;
  logic [DIVIDER_W-1:0] tick_r, tick_nxt;
  logic                 cap_r,  cap_nxt;
  logic [RW-1:0]        rem_r,  rem_nxt;
  logic                 armv_r, armv_nxt;
  logic [STATE_W-1:0]   arms_r, arms_nxt;
  logic [STATE_W-1:0]   prev_r, prev_nxt;
  logic                 done_r, done_nxt;

  logic [RW-1:0]        rem_mid;
  logic [PW:0]          idx_sum;
  logic [PW-1:0]        idx_slot;
  logic [PW-1:0]        last_slot;
  logic                 seen;
  logic                 is_read;

  assign idx_sum   = {1'b0, wp_r} + {1'b0, OFF_TAB[read_offset]};
  assign idx_slot  = (idx_sum >= (PW + 1)'(DEPTH)) ? PW'(idx_sum - (PW + 1)'(DEPTH))
                                                   : idx_sum[PW-1:0];
  assign last_slot = !cap_r          ? wp_r :
                     (wp_r == '0)    ? PW'(DEPTH - 1) : wp_r - 1'b1;

  assign mem_wr_addr = wp_r;
  assign mem_wr_data = sample;

  always_comb begin
    wp_nxt      = wp_r;
    tick_nxt    = tick_r;
    cap_nxt     = cap_r;
    rem_nxt     = rem_r;
    armv_nxt    = armv_r;
    arms_nxt    = arms_r;
    prev_nxt    = prev_r;
    done_nxt    = done_r;
    rem_mid     = rem_r;
    seen        = 1'b0;
    is_read     = 1'b0;
    mem_wr_en   = 1'b0;
    mem_rd_addr = idx_slot;

    case (ttc_op_t'(opcode))
      OP_TICK: begin
        mem_wr_en = accept;
        if (cap_r) begin
          // trigger check on a change of task state
          if (task_state != prev_r) begin
            prev_nxt = task_state;
            if (armv_r && task_state == arms_r) begin
              armv_nxt = 1'b0;
              rem_mid  = RW'(DEPTH / 2);
            end else if (task_state >= cfg.safety_threshold && rem_r == '0) begin
              rem_mid  = RW'(DEPTH / 8);
            end
          end
          rem_nxt = rem_mid;
          if (tick_r >= cfg.sample_divider) begin
            tick_nxt = '0;
            wp_nxt   = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
            if (rem_mid != '0) begin
              if (rem_mid == RW'(1)) begin
                cap_nxt  = 1'b0;
                done_nxt = 1'b1;
              end
              rem_nxt = rem_mid - 1'b1;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
      end
      OP_ARM: begin
        arms_nxt = arm_event;
        armv_nxt = (arm_event != '0);
        cap_nxt  = 1'b1;
      end
      OP_START: cap_nxt = 1'b1;
      OP_STOP:  cap_nxt = 1'b0;
      OP_READ_IDX: begin
        is_read     = 1'b1;
        mem_rd_addr = idx_slot;
      end
      OP_READ_LAST: begin
        is_read     = 1'b1;
        mem_rd_addr = last_slot;
      end
      OP_POLL: begin
        if (done_r && !cap_r) begin
          done_nxt = 1'b0;
          seen     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign flags.is_read   = is_read;
  assign flags.seen      = seen;
  assign flags.capturing = cap_nxt;
  assign write_index     = wp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      tick_r <= '0;
      cap_r  <= 1'b1;
      rem_r  <= '0;
      armv_r <= 1'b0;
      arms_r <= '0;
      prev_r <= '0;
      done_r <= 1'b0;
    end else if (accept) begin
      wp_r   <= wp_nxt;
      tick_r <= tick_nxt;
      cap_r  <= cap_nxt;
      rem_r  <= rem_nxt;
      armv_r <= armv_nxt;
      arms_r <= arms_nxt;
      prev_r <= prev_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/ttc_out_queue.sv
// Result path: a holding stage aligned with the memory read register,
// then the output register. Depends on ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttc_out_queue
  import ttc_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int PW          = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire ttc_flags_t              flags_in,
  input  wire logic [PW-1:0]           widx_in,
  input  wire logic [SAMPLE_WIDTH-1:0] rd_data,
  output logic                         can_accept,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [SAMPLE_WIDTH-1:0] out_read_data,
  output logic                         out_event_seen,
  output logic                         out_capturing,
  output logic      [PW-1:0]           out_write_index
);

  logic                    a_valid_r;
  ttc_flags_t              a_flags_r;
  logic [PW-1:0]           a_widx_r;
  logic                    o_valid_r;
  logic [SAMPLE_WIDTH-1:0] o_data_r;
  logic                    o_seen_r;
  logic                    o_cap_r;
  logic [PW-1:0]           o_widx_r;
  logic                    move;

  assign move       = a_valid_r && (!o_valid_r || !out_stall);
  assign can_accept = !a_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (move) begin
        a_valid_r <= 1'b0;
      end
      if (move) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_flags_r <= flags_in;
      a_widx_r  <= widx_in;
    end
    if (move) begin
      o_data_r <= a_flags_r.is_read ? rd_data : '0;
      o_seen_r <= a_flags_r.seen;
      o_cap_r  <= a_flags_r.capturing;
      o_widx_r <= a_widx_r;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_read_data   = o_data_r;
  assign out_event_seen  = o_seen_r;
  assign out_capturing   = o_cap_r;
  assign out_write_index = o_widx_r;

endmodule

`default_nettype wire
